/* rtl/core/led_fade_slew_engine_macros.svh */
// Assertion macros used by the fade and slew engine top level.
`ifndef LED_FADE_SLEW_ENGINE_MACROS_SVH
`define LED_FADE_SLEW_ENGINE_MACROS_SVH
`ifndef ASSERT_OFF
// Plain property check, sampled on clk and held off while in reset.
`define LFSE_ASSERT(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (prop)) else $error(msg);
// Same-cycle implication check.
`define LFSE_ASSERT_IMP(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) else $error(msg);
`else
`define LFSE_ASSERT(lbl, prop, msg)
`define LFSE_ASSERT_IMP(lbl, ante, cons, msg)
`endif
`endif

/* rtl/core/lfse_pkg.sv */
// Types and constants shared by the fade and slew engine modules.
`default_nettype none
package lfse_pkg;

	// Input item kinds carried on the slave-side tuser.
	typedef enum logic [1:0] {
		KIND_BUTTON = 2'd0,
		KIND_TICK   = 2'd1,
		KIND_ENABLE = 2'd2
	} kind_t;

	// Sequencer states.
	typedef enum logic [1:0] {
		ST_IDLE,
		ST_SLEW,
		ST_REPORT,
		ST_STATUS
	} state_t;

	// Colour channel currently handled by the shared slew unit.
	typedef enum logic [1:0] {
		CH_RED   = 2'd0,
		CH_GREEN = 2'd1,
		CH_BLUE  = 2'd2
	} chan_t;

	// Configuration register indexes.
	localparam logic [2:0] REG_LEVEL_RED   = 3'd0;
	localparam logic [2:0] REG_LEVEL_GREEN = 3'd1;
	localparam logic [2:0] REG_LEVEL_BLUE  = 3'd2;
	localparam logic [2:0] REG_RISE_STEP   = 3'd3;
	localparam logic [2:0] REG_FALL_STEP   = 3'd4;

	// Reset values of the step registers.
	localparam logic [7:0] RISE_STEP_RST = 8'd18;
	localparam logic [7:0] FALL_STEP_RST = 8'd12;

	// Operands handed to the slew unit.
	typedef struct packed {
		logic [7:0] cur;
		logic [7:0] tgt;
		logic [7:0] rise;
		logic [7:0] fall;
	} slew_op_t;

	// Result returned by the slew unit.
	typedef struct packed {
		logic [7:0] nxt;
		logic       moved;
	} slew_res_t;

endpackage
`default_nettype wire

/* rtl/core/lfse_slew.sv */
// Shared slew unit: moves one level toward its target by a bounded step.
`default_nettype none
module lfse_slew (
	input  lfse_pkg::slew_op_t  op,
	output lfse_pkg::slew_res_t res
);

	logic [8:0] sum;
	logic [7:0] gap;
	logic [7:0] dec;
	logic [7:0] nxt;

	// Rise is clamped at the target; fall is limited by the gap to the target.
	always_comb begin
		sum = {1'b0, op.cur} + {1'b0, op.rise};
		gap = op.cur - op.tgt;
		dec = (op.fall < gap) ? op.fall : gap;
		if (op.cur < op.tgt) begin
			nxt = (sum > {1'b0, op.tgt}) ? op.tgt : sum[7:0];
		end else begin
			nxt = op.cur - dec;
		end
		res.nxt   = nxt;
		res.moved = (nxt != op.cur);
	end

endmodule
`default_nettype wire

/* rtl/core/led_fade_slew_engine.sv */
// Top level of the button LED fade and slew engine.
//
// Channel  | Direction | Beat contents (lowest bits first)
// s_*      | in        | tdata: button_index, pressed, enable_value; tuser: kind
// m_*      | out       | tdata: led_index, red, green, blue, status; tuser: is_status
// cfg_*    | in        | one register write per cycle with cfg_we high
//
// A button event gives one status beat.
// A frame tick, while enabled, walks every LED and colour through one shared slew unit,
// one channel per cycle, then gives LED_COUNT report beats if any level moved.
// An enable change clears all flags and levels and gives LED_COUNT zero beats.
// Reset: all flags and levels zero, output enabled, rise step 18, fall step 12.
// Report beats go out at one per cycle while m_tready stays high; a stall holds the walk.
`default_nettype none
`include "led_fade_slew_engine_macros.svh"
module led_fade_slew_engine #(
	parameter int LED_COUNT = 16
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [15:0] s_tdata,   // button_index[7:0], pressed[8], enable_value[9]
	input  logic [1:0]  s_tuser,   // kind[1:0]
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [31:0] m_tdata,   // led_index[3:0], red[11:4], green[19:12], blue[27:20],
	                               // status[28]
	output logic        m_tuser,   // is_status[0]
	output logic        m_tlast,
	input  logic        cfg_we,
	input  logic [2:0]  cfg_index,
	input  logic [7:0]  cfg_data
);

	localparam int IDX_W = (LED_COUNT > 1) ? $clog2(LED_COUNT) : 1;
	localparam logic [IDX_W-1:0] LAST_LED = IDX_W'(LED_COUNT - 1);

	// Configuration registers.
	logic [7:0] level_red_q, level_green_q, level_blue_q, rise_q, fall_q;

	// Per-LED state.
	logic       flags_q [LED_COUNT];
	logic [7:0] red_q   [LED_COUNT];
	logic [7:0] green_q [LED_COUNT];
	logic [7:0] blue_q  [LED_COUNT];
	logic       enabled_q;

	// Sequencer.
	lfse_pkg::state_t state_q, state_d;
	lfse_pkg::chan_t  ch_q;
	logic [IDX_W-1:0] led_q;
	logic             moved_q;
	logic             ld_status, ld_report;

	// Pending status of a button event.
	logic       bad_q;
	logic [3:0] sidx_q;

	// Output register.
	logic       m_tvalid_q;
	logic [3:0] out_idx_q;
	logic [7:0] out_red_q, out_green_q, out_blue_q;
	logic       out_status_q, out_is_status_q, out_last_q;

	// Input decode.
	lfse_pkg::kind_t in_kind;
	logic [7:0]      in_idx;
	logic            in_prs, in_en, in_bad, accept, out_free, last_ch, last_led;

	lfse_pkg::slew_op_t  slew_op;
	lfse_pkg::slew_res_t slew_res;

	assign in_kind  = lfse_pkg::kind_t'(s_tuser);
	assign in_idx   = s_tdata[7:0];
	assign in_prs   = s_tdata[8];
	assign in_en    = s_tdata[9];
	assign in_bad   = (in_idx >= 8'(LED_COUNT));
	assign s_tready = (state_q == lfse_pkg::ST_IDLE);
	assign accept   = s_tvalid && s_tready;
	assign out_free = !m_tvalid_q || m_tready;
	assign last_ch  = (ch_q == lfse_pkg::CH_BLUE);
	assign last_led = (led_q == LAST_LED);

	// Configuration writes.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			level_red_q   <= '0;
			level_green_q <= '0;
			level_blue_q  <= '0;
			rise_q        <= lfse_pkg::RISE_STEP_RST;
			fall_q        <= lfse_pkg::FALL_STEP_RST;
		end else if (cfg_we) begin
			unique case (cfg_index)
				lfse_pkg::REG_LEVEL_RED:   level_red_q   <= cfg_data;
				lfse_pkg::REG_LEVEL_GREEN: level_green_q <= cfg_data;
				lfse_pkg::REG_LEVEL_BLUE:  level_blue_q  <= cfg_data;
				lfse_pkg::REG_RISE_STEP:   rise_q        <= cfg_data;
				lfse_pkg::REG_FALL_STEP:   fall_q        <= cfg_data;
				default: ;
			endcase
		end
	end

	// Operands for the shared slew unit: the current channel of the current LED.
	always_comb begin
		slew_op.rise = rise_q;
		slew_op.fall = fall_q;
		unique case (ch_q)
			lfse_pkg::CH_RED: begin
				slew_op.cur = red_q[led_q];
				slew_op.tgt = flags_q[led_q] ? level_red_q : 8'd0;
			end
			lfse_pkg::CH_GREEN: begin
				slew_op.cur = green_q[led_q];
				slew_op.tgt = flags_q[led_q] ? level_green_q : 8'd0;
			end
			default: begin
				slew_op.cur = blue_q[led_q];
				slew_op.tgt = flags_q[led_q] ? level_blue_q : 8'd0;
			end
		endcase
	end

	lfse_slew u_slew (
		.op  (slew_op),
		.res (slew_res)
	);

	// State register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= lfse_pkg::ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// Next state and load strobes.
	always_comb begin
		state_d   = state_q;
		ld_status = 1'b0;
		ld_report = 1'b0;
		unique case (state_q)
			lfse_pkg::ST_IDLE: begin
				if (accept) begin
					unique case (in_kind)
						lfse_pkg::KIND_BUTTON: state_d = lfse_pkg::ST_STATUS;
						lfse_pkg::KIND_TICK: begin
							if (enabled_q) state_d = lfse_pkg::ST_SLEW;
						end
						lfse_pkg::KIND_ENABLE: begin
							if (in_en != enabled_q) state_d = lfse_pkg::ST_REPORT;
						end
						default: ;
					endcase
				end
			end
			lfse_pkg::ST_SLEW: begin
				if (last_ch && last_led) begin
					state_d = (moved_q || slew_res.moved) ? lfse_pkg::ST_REPORT
					                                      : lfse_pkg::ST_IDLE;
				end
			end
			lfse_pkg::ST_REPORT: begin
				if (out_free) begin
					ld_report = 1'b1;
					if (last_led) state_d = lfse_pkg::ST_IDLE;
				end
			end
			lfse_pkg::ST_STATUS: begin
				if (out_free) begin
					ld_status = 1'b1;
					state_d   = lfse_pkg::ST_IDLE;
				end
			end
			default: state_d = lfse_pkg::ST_IDLE;
		endcase
	end

	// Walk counters over LEDs and channels.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			led_q   <= '0;
			ch_q    <= lfse_pkg::CH_RED;
			moved_q <= 1'b0;
		end else if (accept) begin
			led_q   <= '0;
			ch_q    <= lfse_pkg::CH_RED;
			moved_q <= 1'b0;
		end else if (state_q == lfse_pkg::ST_SLEW) begin
			moved_q <= moved_q || slew_res.moved;
			unique case (ch_q)
				lfse_pkg::CH_RED:   ch_q <= lfse_pkg::CH_GREEN;
				lfse_pkg::CH_GREEN: ch_q <= lfse_pkg::CH_BLUE;
				default: begin
					ch_q  <= lfse_pkg::CH_RED;
					led_q <= last_led ? '0 : led_q + IDX_W'(1);
				end
			endcase
		end else if (ld_report) begin
			led_q <= last_led ? '0 : led_q + IDX_W'(1);
		end
	end

	// Status of a button event, captured when the event is taken.
	always_ff @(posedge clk) begin
		if (accept) begin
			bad_q  <= in_bad;
			sidx_q <= in_idx[3:0];
		end
	end

	// Per-LED flags and levels: button writes, enable clears and slew write-back.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			enabled_q <= 1'b1;
			for (int i = 0; i < LED_COUNT; i++) begin
				flags_q[i] <= 1'b0;
				red_q[i]   <= '0;
				green_q[i] <= '0;
				blue_q[i]  <= '0;
			end
		end else if (accept && in_kind == lfse_pkg::KIND_BUTTON) begin
			if (!in_bad) flags_q[in_idx[IDX_W-1:0]] <= in_prs;
		end else if (accept && in_kind == lfse_pkg::KIND_ENABLE) begin
			if (in_en != enabled_q) begin
				enabled_q <= in_en;
				for (int i = 0; i < LED_COUNT; i++) begin
					flags_q[i] <= 1'b0;
					red_q[i]   <= '0;
					green_q[i] <= '0;
					blue_q[i]  <= '0;
				end
			end
		end else if (state_q == lfse_pkg::ST_SLEW) begin
			unique case (ch_q)
				lfse_pkg::CH_RED:   red_q[led_q]   <= slew_res.nxt;
				lfse_pkg::CH_GREEN: green_q[led_q] <= slew_res.nxt;
				default:            blue_q[led_q]  <= slew_res.nxt;
			endcase
		end
	end

	// Output register valid.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tvalid_q <= 1'b0;
		end else if (ld_status || ld_report) begin
			m_tvalid_q <= 1'b1;
		end else if (m_tready) begin
			m_tvalid_q <= 1'b0;
		end
	end

	// Output register payload.
	always_ff @(posedge clk) begin
		if (ld_status) begin
			out_idx_q       <= bad_q ? 4'd0 : sidx_q;
			out_red_q       <= '0;
			out_green_q     <= '0;
			out_blue_q      <= '0;
			out_status_q    <= bad_q;
			out_is_status_q <= 1'b1;
			out_last_q      <= 1'b1;
		end else if (ld_report) begin
			out_idx_q       <= 4'(led_q);
			out_red_q       <= red_q[led_q];
			out_green_q     <= green_q[led_q];
			out_blue_q      <= blue_q[led_q];
			out_status_q    <= 1'b0;
			out_is_status_q <= 1'b0;
			out_last_q      <= last_led;
		end
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = {3'b000, out_status_q, out_blue_q, out_green_q, out_red_q, out_idx_q};
	assign m_tuser  = out_is_status_q;
	assign m_tlast  = out_last_q;

	// A status beat is always the last beat of its event.
	`LFSE_ASSERT_IMP(a_status_last, m_tvalid && m_tuser, m_tlast, "status beat without tlast")
	// The final report beat carries the highest LED index.
	`LFSE_ASSERT_IMP(a_report_last_idx, m_tvalid && !m_tuser && m_tlast,
		m_tdata[3:0] == 4'(LED_COUNT - 1), "last report beat has wrong LED index")
	// The channel counter never leaves the three colours.
	`LFSE_ASSERT(a_chan_range, ch_q <= lfse_pkg::CH_BLUE, "channel counter out of range")

endmodule
`default_nettype wire

/* verif/tb_led_fade_slew_engine.sv */
`timescale 1ns / 1ps
// Self-checking testbench for the button LED fade and slew engine, table-driven then random.
module tb_led_fade_slew_engine;

	// Codes shared with the design, under the names the stimulus table uses.
	localparam logic [1:0] KIND_BUTTON     = lfse_pkg::KIND_BUTTON;
	localparam logic [1:0] KIND_TICK       = lfse_pkg::KIND_TICK;
	localparam logic [1:0] KIND_ENABLE     = lfse_pkg::KIND_ENABLE;
	localparam logic [2:0] REG_LEVEL_RED   = lfse_pkg::REG_LEVEL_RED;
	localparam logic [2:0] REG_LEVEL_GREEN = lfse_pkg::REG_LEVEL_GREEN;
	localparam logic [2:0] REG_LEVEL_BLUE  = lfse_pkg::REG_LEVEL_BLUE;
	localparam logic [2:0] REG_RISE_STEP   = lfse_pkg::REG_RISE_STEP;
	localparam logic [2:0] REG_FALL_STEP   = lfse_pkg::REG_FALL_STEP;
	localparam logic [7:0] RISE_STEP_RST   = lfse_pkg::RISE_STEP_RST;
	localparam logic [7:0] FALL_STEP_RST   = lfse_pkg::FALL_STEP_RST;

	localparam int LED_COUNT = 16;
	localparam int CLK_HALF = 6;
	localparam int RESET_CYCLES = 9;
	// A frame tick walks 3 * LED_COUNT channel slots before it can report; allow margin.
	localparam int SETTLE_CYCLES = 80;
	localparam int SINK_HOLD_CYCLES = 400;
	localparam int RANDOM_ITEMS = 106;
	localparam int PRESSURE_PHASE = 2;
	localparam int CYCLE_LIMIT = 800000;
	localparam logic [1:0] KIND_UNUSED = 2'd3;
	localparam logic [2:0] REG_UNUSED = 3'd7;

	// One output beat, unpacked from tdata, tuser and tlast.
	typedef struct packed {
		logic [3:0] led;
		logic [7:0] red;
		logic [7:0] green;
		logic [7:0] blue;
		logic       status;
		logic       is_status;
		logic       last;
	} level_beat_t;

	// Directed stimulus: a register write, an item checked against the predictor,
	// or an item whose beats are written out in the row itself.
	typedef enum logic [1:0] {
		ROW_CFG,
		ROW_PREDICT,
		ROW_TYPED
	} row_op_t;

	typedef struct packed {
		row_op_t    op;
		logic [1:0] kind;
		logic [2:0] cfg_reg;
		logic [7:0] value;     // button index for items, register data for writes
		logic       prs;
		logic       en;
		logic [4:0] n_beats;
		logic [3:0] t_led;
		logic       t_status;
	} row_t;

	localparam int DIRECTED_ROWS = 32;

	row_t directed_rows [DIRECTED_ROWS] = '{
		// Straight after reset: colour levels are zero, so nothing can move.
		'{ROW_TYPED,   KIND_TICK,   REG_LEVEL_RED,   8'd0,   1'b0, 1'b0, 5'd0,  4'd0,  1'b0},
		// Presses at both ends of the row, then indexes just and far out of range.
		'{ROW_TYPED,   KIND_BUTTON, REG_LEVEL_RED,   8'd0,   1'b1, 1'b0, 5'd1,  4'd0,  1'b0},
		'{ROW_TYPED,   KIND_BUTTON, REG_LEVEL_RED,   8'd15,  1'b1, 1'b0, 5'd1,  4'd15, 1'b0},
		'{ROW_TYPED,   KIND_BUTTON, REG_LEVEL_RED,   8'd16,  1'b1, 1'b0, 5'd1,  4'd0,  1'b1},
		'{ROW_TYPED,   KIND_BUTTON, REG_LEVEL_RED,   8'd255, 1'b0, 1'b1, 5'd1,  4'd0,  1'b1},
		// Unknown kind and an enable change to the current value are both silent.
		'{ROW_TYPED,   KIND_UNUSED, REG_LEVEL_RED,   8'd255, 1'b1, 1'b1, 5'd0,  4'd0,  1'b0},
		'{ROW_TYPED,   KIND_ENABLE, REG_LEVEL_RED,   8'd0,   1'b0, 1'b1, 5'd0,  4'd0,  1'b0},
		'{ROW_TYPED,   KIND_TICK,   REG_LEVEL_RED,   8'd0,   1'b0, 1'b0, 5'd0,  4'd0,  1'b0},
		// Fade up from full, mid and minimum colour levels.
		'{ROW_CFG,     KIND_BUTTON, REG_LEVEL_RED,   8'd255, 1'b0, 1'b0, 5'd0,  4'd0,  1'b0},
		'{ROW_CFG,     KIND_BUTTON, REG_LEVEL_GREEN, 8'd128, 1'b0, 1'b0, 5'd0,  4'd0,  1'b0},
		'{ROW_CFG,     KIND_BUTTON, REG_LEVEL_BLUE,  8'd1,   1'b0, 1'b0, 5'd0,  4'd0,  1'b0},
		'{ROW_PREDICT, KIND_TICK,   REG_LEVEL_RED,   8'd0,   1'b0, 1'b0, 5'd0,  4'd0,  1'b0},
		'{ROW_PREDICT, KIND_TICK,   REG_LEVEL_RED,   8'd255, 1'b1, 1'b1, 5'd0,  4'd0,  1'b0},
		// Largest rise step jumps straight to the target.
		'{ROW_CFG,     KIND_BUTTON, REG_RISE_STEP,   8'd255, 1'b0, 1'b0, 5'd0,  4'd0,  1'b0},
		'{ROW_PREDICT, KIND_TICK,   REG_LEVEL_RED,   8'd0,   1'b0, 1'b0, 5'd0,  4'd0,  1'b0},
		'{ROW_TYPED,   KIND_BUTTON, REG_LEVEL_RED,   8'd0,   1'b0, 1'b0, 5'd1,  4'd0,  1'b0},
		// A zero fall step holds a released LED, a full one drops it at once.
		'{ROW_CFG,     KIND_BUTTON, REG_FALL_STEP,   8'd0,   1'b0, 1'b0, 5'd0,  4'd0,  1'b0},
		'{ROW_PREDICT, KIND_TICK,   REG_LEVEL_RED,   8'd0,   1'b0, 1'b0, 5'd0,  4'd0,  1'b0},
		'{ROW_CFG,     KIND_BUTTON, REG_FALL_STEP,   8'd255, 1'b0, 1'b0, 5'd0,  4'd0,  1'b0},
		'{ROW_PREDICT, KIND_TICK,   REG_LEVEL_RED,   8'd0,   1'b0, 1'b0, 5'd0,  4'd0,  1'b0},
		// A write beyond the register list is dropped.
		'{ROW_CFG,     KIND_BUTTON, REG_UNUSED,      8'd255, 1'b0, 1'b0, 5'd0,  4'd0,  1'b0},
		// Disable, tick and press while disabled, then enable again.
		'{ROW_TYPED,   KIND_ENABLE, REG_LEVEL_RED,   8'd0,   1'b0, 1'b0, 5'd16, 4'd0,  1'b0},
		'{ROW_TYPED,   KIND_TICK,   REG_LEVEL_RED,   8'd0,   1'b0, 1'b0, 5'd0,  4'd0,  1'b0},
		'{ROW_TYPED,   KIND_BUTTON, REG_LEVEL_RED,   8'd7,   1'b1, 1'b0, 5'd1,  4'd7,  1'b0},
		'{ROW_TYPED,   KIND_ENABLE, REG_LEVEL_RED,   8'd0,   1'b0, 1'b0, 5'd0,  4'd0,  1'b0},
		'{ROW_TYPED,   KIND_ENABLE, REG_LEVEL_RED,   8'd0,   1'b0, 1'b1, 5'd16, 4'd0,  1'b0},
		'{ROW_TYPED,   KIND_TICK,   REG_LEVEL_RED,   8'd0,   1'b0, 1'b0, 5'd0,  4'd0,  1'b0},
		// A zero rise step holds a pressed LED dark.
		'{ROW_CFG,     KIND_BUTTON, REG_RISE_STEP,   8'd0,   1'b0, 1'b0, 5'd0,  4'd0,  1'b0},
		'{ROW_TYPED,   KIND_BUTTON, REG_LEVEL_RED,   8'd3,   1'b1, 1'b0, 5'd1,  4'd3,  1'b0},
		'{ROW_PREDICT, KIND_TICK,   REG_LEVEL_RED,   8'd0,   1'b0, 1'b0, 5'd0,  4'd0,  1'b0},
		'{ROW_CFG,     KIND_BUTTON, REG_RISE_STEP,   RISE_STEP_RST, 1'b0, 1'b0, 5'd0, 4'd0, 1'b0},
		'{ROW_PREDICT, KIND_TICK,   REG_LEVEL_RED,   8'd0,   1'b0, 1'b0, 5'd0,  4'd0,  1'b0}
	};

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        s_tvalid = 1'b0;
	logic        s_tready;
	logic [15:0] s_tdata = '0;    // button_index[7:0], pressed[8], enable_value[9]
	logic [1:0]  s_tuser = '0;    // kind[1:0]
	logic        m_tvalid;
	logic        m_tready = 1'b0;
	logic [31:0] m_tdata;         // led_index[3:0], red[11:4], green[19:12], blue[27:20],
	                              // status[28]
	logic        m_tuser;         // is_status[0]
	logic        m_tlast;
	logic        cfg_we = 1'b0;
	logic [2:0]  cfg_index = '0;
	logic [7:0]  cfg_data = '0;

	// Shadow copy of the engine state and its registers.
	logic [7:0]  shadow_colour [3];
	logic [7:0]  shadow_rise;
	logic [7:0]  shadow_fall;
	logic        shadow_pressed [LED_COUNT];
	logic [7:0]  shadow_level [LED_COUNT][3];
	logic        shadow_enabled;

	level_beat_t predicted_beats [$];
	level_beat_t typed_beats [$];
	level_beat_t expected_reports [$];

	bit          src_gaps = 1'b1;
	bit          sink_gaps = 1'b1;
	bit          sink_hold_req = 1'b0;
	int unsigned sent_items = 0;
	int unsigned level_mismatches = 0;
	int unsigned cycle_count = 0;

	led_fade_slew_engine #(
		.LED_COUNT(LED_COUNT)
	) dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser),
		.m_tlast  (m_tlast),
		.cfg_we   (cfg_we),
		.cfg_index(cfg_index),
		.cfg_data (cfg_data)
	);

	always #(CLK_HALF) clk = ~clk;

	// Works out the beats one input item causes and advances the shadow state.
	function automatic void predict_fade(input logic [1:0] kind, input logic [7:0] idx,
			input logic prs, input logic en);
		bit         moved;
		bit         report;
		logic [7:0] cur;
		logic [7:0] tgt;
		logic [7:0] nxt;
		predicted_beats.delete();
		moved = 1'b0;
		report = 1'b0;
		case (kind)
			KIND_BUTTON: begin
				if (idx < LED_COUNT) begin
					shadow_pressed[idx[3:0]] = prs;
					predicted_beats.push_back('{idx[3:0], 8'd0, 8'd0, 8'd0, 1'b0, 1'b1, 1'b1});
				end else begin
					predicted_beats.push_back('{4'd0, 8'd0, 8'd0, 8'd0, 1'b1, 1'b1, 1'b1});
				end
			end
			KIND_TICK: begin
				if (shadow_enabled) begin
					for (int i = 0; i < LED_COUNT; i++) begin
						for (int c = 0; c < 3; c++) begin
							cur = shadow_level[i][c];
							tgt = shadow_pressed[i] ? shadow_colour[c] : 8'd0;
							if (cur < tgt)
								nxt = ({1'b0, cur} + {1'b0, shadow_rise} > {1'b0, tgt}) ?
									tgt : cur + shadow_rise;
							else if (cur > tgt)
								nxt = (cur - tgt > shadow_fall) ? cur - shadow_fall : tgt;
							else
								nxt = cur;
							if (nxt != cur)
								moved = 1'b1;
							shadow_level[i][c] = nxt;
						end
					end
					report = moved;
				end
			end
			KIND_ENABLE: begin
				if (en != shadow_enabled) begin
					shadow_enabled = en;
					for (int i = 0; i < LED_COUNT; i++) begin
						shadow_pressed[i] = 1'b0;
						for (int c = 0; c < 3; c++)
							shadow_level[i][c] = 8'd0;
					end
					report = 1'b1;
				end
			end
			default: begin
			end
		endcase
		// Level report: every LED in order, the final one marked.
		if (report) begin
			for (int i = 0; i < LED_COUNT; i++)
				predicted_beats.push_back('{4'(i), shadow_level[i][0], shadow_level[i][1],
					shadow_level[i][2], 1'b0, 1'b0, 1'(i == LED_COUNT - 1)});
		end
	endfunction

	function automatic void check_field(input string name, input int unsigned want,
			input int unsigned got);
		if (want != got) begin
			$error("%s expected %0d got %0d", name, want, got);
			level_mismatches++;
		end
	endfunction

	// Offers one item, after a random gap when src_gaps is set, and queues its beats once taken.
	task automatic send_item(input logic [1:0] kind, input logic [7:0] idx, input logic prs,
			input logic en, input bit typed);
		int unsigned gap;
		gap = src_gaps ? $urandom_range(0, 15) : 0;
		if (gap != 0) begin
			s_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tuser <= kind;
		s_tdata <= {6'd0, en, prs, idx};
		do @(posedge clk); while (!s_tready);
		predict_fade(kind, idx, prs, en);
		sent_items++;
		if (typed) begin
			foreach (typed_beats[i])
				expected_reports.push_back(typed_beats[i]);
		end else begin
			foreach (predicted_beats[i])
				expected_reports.push_back(predicted_beats[i]);
		end
	endtask

	// Stops offering, waits for every queued beat, then lets an unreported tick finish.
	task automatic drain_reports();
		s_tvalid <= 1'b0;
		while (expected_reports.size() != 0) @(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic write_reg(input logic [2:0] sel, input logic [7:0] value);
		cfg_we <= 1'b1;
		cfg_index <= sel;
		cfg_data <= value;
		@(posedge clk);
		cfg_we <= 1'b0;
		@(posedge clk);
		case (sel)
			REG_LEVEL_RED:   shadow_colour[0] = value;
			REG_LEVEL_GREEN: shadow_colour[1] = value;
			REG_LEVEL_BLUE:  shadow_colour[2] = value;
			REG_RISE_STEP:   shadow_rise = value;
			REG_FALL_STEP:   shadow_fall = value;
			default: begin
			end
		endcase
	endtask

	// Runaway guard.
	initial begin
		while (cycle_count < CYCLE_LIMIT) begin
			@(posedge clk);
			cycle_count++;
		end
		$display("FAIL");
		$finish;
	end

	// Receiver: random stalls if sink_gaps, a long hold on request; checks each beat.
	initial begin
		int unsigned stall;
		level_beat_t got;
		level_beat_t want;
		while (!arst_n) @(posedge clk);
		forever begin
			if (sink_hold_req) begin
				sink_hold_req = 1'b0;
				stall = SINK_HOLD_CYCLES;
			end else begin
				stall = sink_gaps ? $urandom_range(0, 15) : 0;
			end
			if (stall != 0) begin
				m_tready <= 1'b0;
				repeat (stall) @(posedge clk);
			end
			m_tready <= 1'b1;
			do @(posedge clk); while (!m_tvalid);
			got = '{m_tdata[3:0], m_tdata[11:4], m_tdata[19:12], m_tdata[27:20], m_tdata[28],
				m_tuser, m_tlast};
			if (expected_reports.size() == 0) begin
				$error("unexpected beat for led_index %0d", got.led);
				level_mismatches++;
			end else begin
				want = expected_reports.pop_front();
				check_field("led_index", want.led, got.led);
				check_field("red_out", want.red, got.red);
				check_field("green_out", want.green, got.green);
				check_field("blue_out", want.blue, got.blue);
				check_field("status", want.status, got.status);
				check_field("is_status", want.is_status, got.is_status);
				check_field("last", want.last, got.last);
			end
		end
	end

	// Sender: reset, directed table, then random phases.
	initial begin
		row_t        row;
		int unsigned phase;
		int unsigned goal;
		int unsigned presses;
		int unsigned ticks;
		logic [7:0]  value;

		foreach (shadow_colour[c])
			shadow_colour[c] = 8'd0;
		shadow_rise = RISE_STEP_RST;
		shadow_fall = FALL_STEP_RST;
		shadow_enabled = 1'b1;
		for (int i = 0; i < LED_COUNT; i++) begin
			shadow_pressed[i] = 1'b0;
			for (int c = 0; c < 3; c++)
				shadow_level[i][c] = 8'd0;
		end

		repeat (RESET_CYCLES) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed rows; register writes only once the engine is quiet.
		for (int r = 0; r < DIRECTED_ROWS; r++) begin
			row = directed_rows[r];
			if (row.op == ROW_CFG) begin
				drain_reports();
				write_reg(row.cfg_reg, row.value);
			end else begin
				typed_beats.delete();
				if (row.n_beats == 1)
					typed_beats.push_back('{row.t_led, 8'd0, 8'd0, 8'd0, row.t_status,
						1'b1, 1'b1});
				else
					for (int i = 0; i < row.n_beats; i++)
						typed_beats.push_back('{4'(i), 8'd0, 8'd0, 8'd0, 1'b0, 1'b0,
							1'(i == row.n_beats - 1)});
				send_item(row.kind, row.value, row.prs, row.en, row.op == ROW_TYPED);
			end
		end

		// Random phases: new settings, then presses followed by a run of ticks with noise.
		goal = sent_items + RANDOM_ITEMS;
		phase = 0;
		while (sent_items < goal) begin
			drain_reports();
			for (int r = REG_LEVEL_RED; r <= REG_UNUSED; r++) begin
				if ($urandom_range(0, 2) == 0) begin
					case ($urandom_range(0, 3))
						0: value = 8'd0;
						1: value = 8'hFF;
						default: value = (r >= REG_RISE_STEP) ? 8'($urandom_range(1, 40)) :
							8'($urandom);
					endcase
					write_reg(3'(r), value);
				end
			end
			src_gaps = $urandom_range(0, 3) != 0;
			sink_gaps = $urandom_range(0, 3) != 0;

			if (phase == PRESSURE_PHASE) begin
				// Long receiver hold while two full reports pile up behind it.
				sink_hold_req = 1'b1;
				send_item(KIND_ENABLE, 8'($urandom), 1'($urandom), !shadow_enabled, 1'b0);
				send_item(KIND_ENABLE, 8'($urandom), 1'($urandom), !shadow_enabled, 1'b0);
			end else if (!shadow_enabled && $urandom_range(0, 3) != 0) begin
				send_item(KIND_ENABLE, 8'($urandom), 1'($urandom), 1'b1, 1'b0);
			end

			presses = $urandom_range(1, 6);
			for (int p = 0; p < presses; p++)
				send_item(KIND_BUTTON, 8'($urandom_range(0, LED_COUNT - 1)),
					1'($urandom_range(0, 3) != 0), 1'($urandom), 1'b0);

			ticks = $urandom_range(1, 8);
			for (int t = 0; t < ticks; t++) begin
				send_item(KIND_TICK, 8'($urandom), 1'($urandom), 1'($urandom), 1'b0);
				if ($urandom_range(0, 4) == 0) begin
					case ($urandom_range(0, 3))
						0: send_item(KIND_BUTTON, 8'($urandom_range(LED_COUNT, 255)),
							1'($urandom), 1'($urandom), 1'b0);
						1: send_item(KIND_UNUSED, 8'($urandom), 1'($urandom), 1'($urandom),
							1'b0);
						2: send_item(KIND_ENABLE, 8'($urandom), 1'($urandom), 1'($urandom),
							1'b0);
						default: send_item(KIND_BUTTON, 8'($urandom_range(0, LED_COUNT - 1)),
							1'b0, 1'($urandom), 1'b0);
					endcase
				end
			end
			phase++;
		end

		drain_reports();
		if (level_mismatches == 0)
			$display("PASS");
		else
			$display("FAIL");
		$finish;
	end

endmodule

/* led_fade_slew_engine.f */
+incdir+rtl/core
rtl/core/lfse_pkg.sv
rtl/core/lfse_slew.sv
rtl/core/led_fade_slew_engine.sv
verif/tb_led_fade_slew_engine.sv
